// ===== hw/rtl/fmo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmo_pkg
// Shared types, constants and arithmetic helpers of the FM oscillator.
// ----------------------------------------------------------------------------
package fmo_pkg;

	localparam int DEF_CHANNELS         = 16;
	localparam int DEF_SINE_TABLE_DEPTH = 2048;

	localparam int CHAN_W   = 4;
	localparam int FIELD_W  = 24;
	localparam int SAMPLE_W = 16;
	localparam int PHASE_W  = 32;
	localparam int FREQ_W   = FIELD_W + 1;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RATIO_MODE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_PER_HZ = 1'd1;

	localparam logic [PHASE_W-1:0] PPH_RESET = 32'd22906492;

	// shared multiplier: signed operands, full product
	localparam int MUL_W = 34;
	localparam int MUL_P = 2 * MUL_W;

	localparam logic signed [MUL_W-1:0] C1 = MUL_W'(1686629713);
	localparam logic signed [MUL_W-1:0] C3 = MUL_W'(693598668);
	localparam logic signed [MUL_W-1:0] C5 = MUL_W'(85569306);
	localparam logic signed [MUL_W-1:0] C7 = MUL_W'(5026996);
	localparam logic signed [MUL_W-1:0] C9 = MUL_W'(172272);

	localparam logic signed [MUL_P-1:0] Q30_RND  = MUL_P'(32'h3FFF_FFFF);
	localparam logic signed [MUL_P-1:0] Q24_MAX  = MUL_P'(8388607);
	localparam logic signed [MUL_P-1:0] Q24_MIN  = -MUL_P'(8388608);
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RD,
		ST_RATIO,
		ST_RATIO_WB,
		ST_POS,
		ST_POS_WB,
		ST_EQ,
		ST_EQ_WB,
		ST_ERM,
		ST_ERM_WB,
		ST_EM,
		ST_EM_WB,
		ST_FOLD,
		ST_UU,
		ST_UU_WB,
		ST_HORN,
		ST_HORN_WB,
		ST_FIN,
		ST_FIN_WB,
		ST_INTERP,
		ST_INTERP_WB,
		ST_DEV,
		ST_DEV_WB,
		ST_INC_C,
		ST_INC_C_WB,
		ST_INC_M,
		ST_INC_M_WB,
		ST_WR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic rd;
		logic wr;
	} mem_cmd_t;

	typedef struct packed {
		logic                ratio_mode;
		logic [PHASE_W-1:0]  phase_per_hz;
	} cfg_t;

	typedef struct packed {
		logic                       valid;
		logic [CHAN_W-1:0]          out_channel;
		logic signed [SAMPLE_W-1:0] sample;
	} res_t;

	// product / 2^30, truncated toward zero
	function automatic logic signed [MUL_W-1:0] trunc_q30(input logic signed [MUL_P-1:0] p);
		logic signed [MUL_P-1:0] t;
		t = p[MUL_P-1] ? p + Q30_RND : p;
		t = t >>> 30;
		return t[MUL_W-1:0];
	endfunction

	// Horner coefficients, highest order first after C9
	function automatic logic signed [MUL_W-1:0] horner_coef(input logic [1:0] i);
		logic signed [MUL_W-1:0] c;
		case (i)
			2'd0:    c = -C7;
			2'd1:    c = C5;
			2'd2:    c = -C3;
			default: c = C1;
		endcase
		return c;
	endfunction

	// Q30 magnitude to Q15, clamp, apply quadrant sign
	function automatic logic signed [SAMPLE_W-1:0] sine_round(
		input logic signed [MUL_W-1:0] r,
		input logic                    neg
	);
		logic signed [MUL_W-1:0] t;
		logic [SAMPLE_W-1:0]     v;
		t = r[MUL_W-1] ? '0 : r;
		t = (t + MUL_W'(16384)) >>> 15;
		if (t > MUL_W'(32767))
			v = 16'h7FFF;
		else
			v = t[SAMPLE_W-1:0];
		return neg ? -v : v;
	endfunction

endpackage

// ===== hw/rtl/fmo_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmo_if
// Valid/ready channels of the FM oscillator: request, result and config.
// ----------------------------------------------------------------------------
interface fmo_item_if import fmo_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [CHAN_W-1:0]          channel;
	logic signed [FIELD_W-1:0]  carrier_freq;
	logic signed [FIELD_W-1:0]  mod_value;
	logic signed [FIELD_W-1:0]  mod_index;

	modport source (output valid, channel, carrier_freq, mod_value, mod_index, input ready);
	modport sink   (input valid, channel, carrier_freq, mod_value, mod_index, output ready);
endinterface

interface fmo_result_if import fmo_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [CHAN_W-1:0]          out_channel;
	logic signed [SAMPLE_W-1:0] sample;

	modport source (output valid, out_channel, sample, input ready);
	modport sink   (input valid, out_channel, sample, output ready);
endinterface

interface fmo_cfg_if import fmo_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/fmo_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmo_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module fmo_mul import fmo_pkg::*; (
	input  logic                    clk,
	input  logic signed [MUL_W-1:0] a,
	input  logic signed [MUL_W-1:0] b,
	output logic signed [MUL_P-1:0] p
);

	logic signed [MUL_P-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= MUL_P'(a) * MUL_P'(b);
	end

	assign p = p_q;

endmodule

// ===== hw/rtl/fmo_phase_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmo_phase_mem
// Per-channel carrier/modulator phase pair store with registered read.
// ----------------------------------------------------------------------------
module fmo_phase_mem import fmo_pkg::*; #(
	parameter int CHANNELS = DEF_CHANNELS,
	parameter int CH_AW    = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mem_cmd_t               cmd,
	input  logic [CH_AW-1:0]       addr,
	input  logic [2*PHASE_W-1:0]   wdata,
	output logic [2*PHASE_W-1:0]   rdata
);

	logic [2*PHASE_W-1:0] mem [CHANNELS];
	logic [CHANNELS-1:0]  vld_q;
	logic [2*PHASE_W-1:0] rd_q;
	logic                 rd_vld_q;

	// an entry never written reads as zero phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.wr) begin
			vld_q[addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr)
			mem[addr] <= wdata;
		if (cmd.rd) begin
			rd_q     <= mem[addr];
			rd_vld_q <= vld_q[addr];
		end
	end

	assign rdata = rd_vld_q ? rd_q : '0;

endmodule

// ===== hw/rtl/fmo_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmo_core
// Sequencer and datapath: table sines, deviation and phase increments, all
// through one shared multiplier.
// ----------------------------------------------------------------------------
module fmo_core import fmo_pkg::*; #(
	parameter int CHANNELS         = DEF_CHANNELS,
	parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH,
	parameter int CH_AW            = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	fmo_item_if.sink               item,
	input  cfg_t                   cfg,
	output res_t                   res,
	input  logic                   take,
	output mem_cmd_t               cmd,
	output logic [CH_AW-1:0]       addr,
	output logic [2*PHASE_W-1:0]   wdata,
	input  logic [2*PHASE_W-1:0]   rdata
);

	localparam int AW = $clog2(SINE_TABLE_DEPTH);
	localparam longint unsigned TURN = 64'h1_0000_0000;
	// table entry k sits at k*Q + floor(k*R / depth)
	localparam longint unsigned QT   = TURN / SINE_TABLE_DEPTH;
	localparam longint unsigned RT   = TURN % SINE_TABLE_DEPTH;
	localparam int RS = 3 * AW;
	localparam longint unsigned RM   = ((64'd1 << RS) + SINE_TABLE_DEPTH - 1) / SINE_TABLE_DEPTH;

	state_t state_q, state_d;

	logic                        sel_q;
	logic                        ent_q;
	logic [1:0]                  hcnt_q;

	logic [CHAN_W-1:0]           ch_q;
	logic [CH_AW-1:0]            addr_q;
	logic                        ok_q;
	logic signed [FIELD_W-1:0]   car_q;
	logic signed [FIELD_W-1:0]   mod_q;
	logic signed [FIELD_W-1:0]   ndx_q;
	logic [PHASE_W-1:0]          cph_q;
	logic [PHASE_W-1:0]          mph_q;
	logic [AW-1:0]               kbase_q;
	logic [PHASE_W-1:0]          frac_q;
	logic [PHASE_W:0]            eq_q;
	logic [PHASE_W-1:0]          x_q;
	logic [PHASE_W-1:0]          eph_q;
	logic [1:0]                  quad_q;
	logic [30:0]                 u_q;
	logic [30:0]                 u2_q;
	logic signed [MUL_W-1:0]     acc_q;
	logic signed [SAMPLE_W-1:0]  ea_q;
	logic signed [SAMPLE_W-1:0]  eb_q;
	logic signed [SAMPLE_W-1:0]  sm_q;
	logic signed [SAMPLE_W-1:0]  smp_q;
	logic signed [FREQ_W-1:0]    freq_q;

	logic signed [MUL_W-1:0]     mul_a;
	logic signed [MUL_W-1:0]     mul_b;
	logic signed [MUL_P-1:0]     p;

	logic                        in_rng;
	logic [CH_AW+CHAN_W-1:0]     ch_ext;
	logic [AW:0]                 k;
	logic [PHASE_W-1:0]          sin_ph;
	logic signed [SAMPLE_W:0]    d;
	logic signed [SAMPLE_W:0]    d_abs;
	logic                        accept;

	logic signed [MUL_P-1:0]     sh_s;
	logic [MUL_P-1:0]            q_sh;
	logic [MUL_P-1:0]            rnd;
	logic [SAMPLE_W:0]           mag;
	logic signed [SAMPLE_W+1:0]  s18;
	logic signed [SAMPLE_W-1:0]  snew;

	fmo_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (p)
	);

	assign in_rng = (32'(item.channel) < CHANNELS);
	assign ch_ext = {{CH_AW{1'b0}}, item.channel};
	assign accept = item.valid && item.ready;
	assign k      = {1'b0, kbase_q} + (AW+1)'(ent_q);
	assign sin_ph = sel_q ? cph_q : mph_q;
	assign d      = (SAMPLE_W+1)'(eb_q) - (SAMPLE_W+1)'(ea_q);
	assign d_abs  = d[SAMPLE_W] ? -d : d;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:      if (item.valid) state_d = in_rng ? ST_RD : ST_DONE;
			ST_RD:        state_d = cfg.ratio_mode ? ST_RATIO : ST_POS;
			ST_RATIO:     state_d = ST_RATIO_WB;
			ST_RATIO_WB:  state_d = ST_POS;
			ST_POS:       state_d = ST_POS_WB;
			ST_POS_WB:    state_d = ST_EQ;
			ST_EQ:        state_d = ST_EQ_WB;
			ST_EQ_WB:     state_d = ST_ERM;
			ST_ERM:       state_d = ST_ERM_WB;
			ST_ERM_WB:    state_d = ST_EM;
			ST_EM:        state_d = ST_EM_WB;
			ST_EM_WB:     state_d = ST_FOLD;
			ST_FOLD:      state_d = ST_UU;
			ST_UU:        state_d = ST_UU_WB;
			ST_UU_WB:     state_d = ST_HORN;
			ST_HORN:      state_d = ST_HORN_WB;
			ST_HORN_WB:   state_d = (hcnt_q == 2'd3) ? ST_FIN : ST_HORN;
			ST_FIN:       state_d = ST_FIN_WB;
			ST_FIN_WB:    state_d = ent_q ? ST_INTERP : ST_EQ;
			ST_INTERP:    state_d = ST_INTERP_WB;
			ST_INTERP_WB: state_d = sel_q ? ST_DEV : ST_POS;
			ST_DEV:       state_d = ST_DEV_WB;
			ST_DEV_WB:    state_d = ST_INC_C;
			ST_INC_C:     state_d = ST_INC_C_WB;
			ST_INC_C_WB:  state_d = ST_INC_M;
			ST_INC_M:     state_d = ST_INC_M_WB;
			ST_INC_M_WB:  state_d = ST_WR;
			ST_WR:        state_d = ST_DONE;
			ST_DONE:      if (take) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// outputs and multiplier operands
	always_comb begin
		item.ready = (state_q == ST_IDLE);
		cmd.rd     = (state_q == ST_IDLE) && item.valid;
		cmd.wr     = (state_q == ST_WR);
		addr       = (state_q == ST_IDLE) ? ch_ext[CH_AW-1:0] : addr_q;
		wdata      = {cph_q, mph_q};
		res.valid       = (state_q == ST_DONE);
		res.out_channel = ch_q;
		res.sample      = smp_q;
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_RATIO: begin
				mul_a = MUL_W'(mod_q);
				mul_b = MUL_W'(car_q);
			end
			ST_POS: begin
				mul_a = MUL_W'(sin_ph);
				mul_b = MUL_W'(SINE_TABLE_DEPTH);
			end
			ST_EQ: begin
				mul_a = MUL_W'(k);
				mul_b = MUL_W'(QT);
			end
			ST_ERM: begin
				mul_a = MUL_W'(k);
				mul_b = MUL_W'(RT);
			end
			ST_EM: begin
				mul_a = MUL_W'(x_q);
				mul_b = MUL_W'(RM);
			end
			ST_UU: begin
				mul_a = MUL_W'(u_q);
				mul_b = MUL_W'(u_q);
			end
			ST_HORN: begin
				mul_a = acc_q;
				mul_b = MUL_W'(u2_q);
			end
			ST_FIN: begin
				mul_a = acc_q;
				mul_b = MUL_W'(u_q);
			end
			ST_INTERP: begin
				mul_a = MUL_W'(d_abs);
				mul_b = MUL_W'(frac_q);
			end
			ST_DEV: begin
				mul_a = MUL_W'(sm_q);
				mul_b = MUL_W'(ndx_q);
			end
			ST_INC_C: begin
				mul_a = MUL_W'(freq_q);
				mul_b = MUL_W'(cfg.phase_per_hz);
			end
			ST_INC_M: begin
				mul_a = MUL_W'(mod_q);
				mul_b = MUL_W'(cfg.phase_per_hz);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// product post-processing
	always_comb begin
		sh_s = '0;
		q_sh = p >> RS;
		rnd  = p + MUL_P'(64'h8000_0000);
		mag  = rnd[PHASE_W +: SAMPLE_W+1];
		s18  = d[SAMPLE_W] ? (SAMPLE_W+2)'(ea_q) - (SAMPLE_W+2)'(mag)
		                   : (SAMPLE_W+2)'(ea_q) + (SAMPLE_W+2)'(mag);
		snew = s18[SAMPLE_W-1:0];
		case (state_q)
			ST_RATIO_WB: sh_s = p >>> 8;
			ST_DEV_WB:   sh_s = p >>> 15;
			default:     sh_s = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= 1'b0;
			ent_q   <= 1'b0;
			hcnt_q  <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_RD:        begin
					sel_q <= 1'b0;
					ent_q <= 1'b0;
				end
				ST_UU_WB:     hcnt_q <= '0;
				ST_HORN_WB:   hcnt_q <= hcnt_q + 2'd1;
				ST_FIN_WB:    ent_q  <= ~ent_q;
				ST_INTERP_WB: sel_q  <= 1'b1;
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (accept) begin
				ch_q   <= item.channel;
				addr_q <= ch_ext[CH_AW-1:0];
				ok_q   <= in_rng;
				car_q  <= item.carrier_freq;
				mod_q  <= item.mod_value;
				ndx_q  <= item.mod_index;
				smp_q  <= '0;
			end
			ST_RD: begin
				cph_q <= rdata[2*PHASE_W-1:PHASE_W];
				mph_q <= rdata[PHASE_W-1:0];
			end
			ST_RATIO_WB: begin
				// floor to Q16.8, saturate to 24 bits
				if (sh_s > Q24_MAX)
					mod_q <= Q24_MAX[FIELD_W-1:0];
				else if (sh_s < Q24_MIN)
					mod_q <= Q24_MIN[FIELD_W-1:0];
				else
					mod_q <= sh_s[FIELD_W-1:0];
			end
			ST_POS_WB: begin
				kbase_q <= p[PHASE_W +: AW];
				frac_q  <= p[PHASE_W-1:0];
			end
			ST_EQ_WB:  eq_q  <= p[PHASE_W:0];
			ST_ERM_WB: x_q   <= p[PHASE_W-1:0];
			ST_EM_WB:  eph_q <= eq_q[PHASE_W-1:0] + q_sh[PHASE_W-1:0];
			ST_FOLD: begin
				quad_q <= eph_q[31:30];
				u_q    <= eph_q[30] ? (31'h4000_0000 - {1'b0, eph_q[29:0]})
				                    : {1'b0, eph_q[29:0]};
			end
			ST_UU_WB: begin
				u2_q  <= p[60:30];
				acc_q <= C9;
			end
			ST_HORN_WB: acc_q <= horner_coef(hcnt_q) + trunc_q30(p);
			ST_FIN_WB: begin
				if (ent_q)
					eb_q <= sine_round(trunc_q30(p), quad_q[1]);
				else
					ea_q <= sine_round(trunc_q30(p), quad_q[1]);
			end
			ST_INTERP_WB: begin
				if (sel_q)
					smp_q <= snew;
				else
					sm_q  <= snew;
			end
			ST_DEV_WB:   freq_q <= FREQ_W'(car_q) + $signed(sh_s[FREQ_W-1:0]);
			ST_INC_C_WB: cph_q  <= cph_q + p[47:16];
			ST_INC_M_WB: mph_q  <= mph_q + p[47:16];
			default:     ;
		endcase
	end

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !ok_q |-> res.sample == '0)
		else $error("out-of-range channel gave a nonzero sample");

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |-> ok_q)
		else $error("phase write for an out-of-range channel");

	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_rng |=> state_q == ST_RD)
		else $error("accepted request did not start a phase read");

	a_entry_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INTERP |-> ea_q != SAMPLE_MIN && eb_q != SAMPLE_MIN)
		else $error("sine table entry out of Q1.15 range");

endmodule

// ===== hw/rtl/fm_oscillator_multichannel_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fm_oscillator_multichannel_top
// Two-operator FM oscillator bank with one phase pair per channel.
// ----------------------------------------------------------------------------
// An accepted request runs the whole product sequence below before the next
// request can be accepted; a request for a channel at or beyond CHANNELS goes
// straight to its result and leaves the phases alone. Every product (the
// ratio product in ratio mode, sine table positions, the degree-9 sine
// polynomial for both table entries of both sines, the interpolation, the
// deviation and both phase increments) goes through one shared registered
// multiplier. A finished result moves to an output register, so the next
// request is taken while the last result waits; a result held longer than
// one request's work stalls the sequencer until the output register frees up.
// ----------------------------------------------------------------------------
module fm_oscillator_multichannel_top import fmo_pkg::*; #(
	parameter int CHANNELS         = DEF_CHANNELS,
	parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	fmo_cfg_if.sink       cfg,
	fmo_item_if.sink      item,
	fmo_result_if.source  result
);

	localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	cfg_t                       cfg_q;
	res_t                       res;
	logic                       take;
	mem_cmd_t                   cmd;
	logic [CH_AW-1:0]           addr;
	logic [2*PHASE_W-1:0]       wdata;
	logic [2*PHASE_W-1:0]       rdata;

	logic                       out_vld_q;
	logic [CHAN_W-1:0]          out_ch_q;
	logic signed [SAMPLE_W-1:0] out_smp_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ratio_mode   <= 1'b0;
			cfg_q.phase_per_hz <= PPH_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_RATIO_MODE:   cfg_q.ratio_mode   <= cfg.data[0];
				REG_PHASE_PER_HZ: cfg_q.phase_per_hz <= cfg.data;
				default:          ;
			endcase
		end
	end

	fmo_core #(
		.CHANNELS         (CHANNELS),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
		.CH_AW            (CH_AW)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cfg    (cfg_q),
		.res    (res),
		.take   (take),
		.cmd    (cmd),
		.addr   (addr),
		.wdata  (wdata),
		.rdata  (rdata)
	);

	fmo_phase_mem #(
		.CHANNELS (CHANNELS),
		.CH_AW    (CH_AW)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.addr   (addr),
		.wdata  (wdata),
		.rdata  (rdata)
	);

	// load the output register when it is empty or being drained
	assign take = res.valid && (!out_vld_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (take) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_ch_q  <= res.out_channel;
			out_smp_q <= res.sample;
		end
	end

	assign result.valid       = out_vld_q;
	assign result.out_channel = out_ch_q;
	assign result.sample      = out_smp_q;

endmodule
